>>> hw/rtl/hav_pkg.sv
// ----------------------------------------------------------------------------
// hav_pkg
// Shared types and constants of the hashed access vector table.
// ----------------------------------------------------------------------------
package hav_pkg;

  localparam int KEY_W      = 64;
  localparam int VEC_W      = 64;
  localparam int ORDER_W    = 5;
  localparam int BITPOS_W   = 6;
  localparam int SLOT_OUT_W = 9;

  typedef enum logic [1:0] {
    KIND_PROBE,
    KIND_IGNORE,
    KIND_FULL
  } hav_kind_t;

  typedef struct packed {
    hav_kind_t             kind;
    logic                  mode;
    logic [KEY_W-1:0]      key;
    logic [BITPOS_W-1:0]   bitpos;
  } hav_cmd_t;

endpackage

>>> hw/rtl/hav_ram.sv
// ----------------------------------------------------------------------------
// hav_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hav_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/hav_fifo.sv
// ----------------------------------------------------------------------------
// hav_fifo
// Two-entry queue between the hashing front and the probing back.
// ----------------------------------------------------------------------------
module hav_fifo #(
  parameter int WIDTH = 80
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign rdata   = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/hav_front.sv
// ----------------------------------------------------------------------------
// hav_front
// Accepts access transactions, classifies them and hashes the key to its
// starting slot.
// ----------------------------------------------------------------------------
module hav_front import hav_pkg::*; #(
  parameter int TABLE_ENTRIES = 512,
  parameter int TASK_SLOTS    = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_mode,
  input  logic [KEY_W-1:0]                 in_key,
  input  logic [ORDER_W-1:0]               in_task_order,
  output logic                             push,
  input  logic                             fifo_full,
  output hav_cmd_t                         cmd,
  output logic [$clog2(TABLE_ENTRIES)-1:0] start
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int RW    = IDX_W + 4;
  localparam bit POW2  = ((1 << IDX_W) == TABLE_ENTRIES);
  localparam logic [9:0] TS = 10'(TASK_SLOTS);
  localparam logic [RW-1:0] NE = RW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_MOD,
    F_PUSH
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [3:0]       nib_r, nib_nxt;
  logic [KEY_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  hav_cmd_t         cmd_r, cmd_nxt;
  logic             mon_r, mon_nxt;
  logic [KEY_W-1:0] t;
  logic [KEY_W-1:0] hash_step;
  logic [RW-1:0]    red;
  logic [9:0]       ord;
  logic             accept;

  assign in_ready = (state_r == F_IDLE) || ((state_r == F_PUSH) && !fifo_full);
  assign accept   = in_valid && in_ready;
  assign push     = (state_r == F_PUSH);
  assign cmd      = cmd_r;
  assign start    = start_r;

  always_comb begin
    t = k_r;
    hash_step = k_r;
    case (step_r)
      2'd0: begin
        hash_step = (~k_r) + (k_r << 21);
      end
      2'd1: begin
        t = k_r ^ (k_r >> 24);
        hash_step = t + (t << 3) + (t << 8);
      end
      2'd2: begin
        t = k_r ^ (k_r >> 14);
        hash_step = t + (t << 2) + (t << 4);
      end
      default: begin
        t = k_r ^ (k_r >> 28);
        hash_step = t + (t << 31);
      end
    endcase
  end

  always_comb begin
    red = {rem_r, k_r[KEY_W-1 -: 4]};
    for (int j = 3; j >= 0; j--) begin
      if (red >= (NE << j)) begin
        red = red - (NE << j);
      end
    end
  end

  always_comb begin
    ord = 10'(in_task_order);
    for (int j = 4; j >= 0; j--) begin
      if (ord >= (TS << j)) begin
        ord = ord - (TS << j);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    nib_nxt   = nib_r;
    k_nxt     = k_r;
    rem_nxt   = rem_r;
    start_nxt = start_r;
    cmd_nxt   = cmd_r;
    mon_nxt   = cfg_we ? cfg_wdata : mon_r;
    unique case (state_r)
      F_IDLE: begin
        state_nxt = F_IDLE;
      end
      F_HASH: begin
        k_nxt    = hash_step;
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          if (POW2) begin
            start_nxt = hash_step[IDX_W-1:0];
            state_nxt = F_PUSH;
          end else begin
            rem_nxt   = '0;
            nib_nxt   = 4'd0;
            state_nxt = F_MOD;
          end
        end
      end
      F_MOD: begin
        k_nxt   = k_r << 4;
        rem_nxt = red[IDX_W-1:0];
        nib_nxt = nib_r + 4'd1;
        if (nib_r == 4'hF) begin
          start_nxt = red[IDX_W-1:0];
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!fifo_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
    if (accept) begin
      k_nxt          = in_key;
      step_nxt       = 2'd0;
      cmd_nxt.mode   = in_mode;
      cmd_nxt.key    = in_key;
      cmd_nxt.bitpos = {ord[ORDER_W-1:0], in_mode};
      if (!mon_r) begin
        cmd_nxt.kind = KIND_IGNORE;
      end else if (in_key == '0) begin
        cmd_nxt.kind = KIND_FULL;
      end else begin
        cmd_nxt.kind = KIND_PROBE;
      end
      state_nxt = F_HASH;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    nib_r   <= nib_nxt;
    k_r     <= k_nxt;
    rem_r   <= rem_nxt;
    start_r <= start_nxt;
    cmd_r   <= cmd_nxt;
    if (!rst_n) begin
      state_r <= F_IDLE;
      mon_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      mon_r   <= mon_nxt;
    end
  end

endmodule

>>> hw/rtl/hav_back.sv
// ----------------------------------------------------------------------------
// hav_back
// Probes the slot memories linearly, claims or updates a slot and registers
// the result transaction.
// ----------------------------------------------------------------------------
module hav_back import hav_pkg::*; #(
  parameter int TABLE_ENTRIES = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fifo_valid,
  input  hav_cmd_t                         fifo_cmd,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] fifo_start,
  output logic                             fifo_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [SLOT_OUT_W-1:0]            out_slot_index,
  output logic [VEC_W-1:0]                 out_prior_vector,
  output logic                             out_first_write,
  output logic                             out_table_full,
  output logic                             out_ignored
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        clr_r, clr_nxt;
  logic [IDX_W-1:0]        addr_r, addr_nxt;
  logic [IDX_W-1:0]        cnt_r, cnt_nxt;
  hav_cmd_t                cmd_r, cmd_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SLOT_OUT_W-1:0]   slot_r, slot_nxt;
  logic [VEC_W-1:0]        old_r, old_nxt;
  logic                    fw_r, fw_nxt;
  logic                    full_r, full_nxt;
  logic                    ign_r, ign_nxt;

  logic                    out_free;
  logic [IDX_W-1:0]        addr_inc;
  logic [IDX_W-1:0]        raddr;
  logic [IDX_W-1:0]        waddr;
  logic                    we;
  logic [KEY_W-1:0]        wkey, rkey;
  logic [VEC_W-1:0]        wvec, rvec;
  logic [VEC_W-1:0]        bit_mask;
  logic                    claim;

  hav_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wkey),
    .raddr (raddr),
    .rdata (rkey)
  );

  hav_ram #(.WIDTH(VEC_W), .DEPTH(TABLE_ENTRIES)) u_vec_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wvec),
    .raddr (raddr),
    .rdata (rvec)
  );

  assign out_free = !out_valid_r || out_ready;
  assign addr_inc = (addr_r == LAST) ? '0 : addr_r + 1'b1;
  assign raddr    = (state_r == B_IDLE) ? fifo_start : addr_inc;
  assign bit_mask = VEC_W'(1) << cmd_r.bitpos;
  assign claim    = (rkey == cmd_r.key) || (rkey == '0);

  assign out_valid        = out_valid_r;
  assign out_slot_index   = slot_r;
  assign out_prior_vector = old_r;
  assign out_first_write  = fw_r;
  assign out_table_full   = full_r;
  assign out_ignored      = ign_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    slot_nxt      = slot_r;
    old_nxt       = old_r;
    fw_nxt        = fw_r;
    full_nxt      = full_r;
    ign_nxt       = ign_r;
    fifo_pop      = 1'b0;
    we            = 1'b0;
    waddr         = addr_r;
    wkey          = cmd_r.key;
    wvec          = rvec | bit_mask;
    unique case (state_r)
      B_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wkey    = '0;
        wvec    = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (fifo_valid && out_free) begin
          fifo_pop = 1'b1;
          cmd_nxt  = fifo_cmd;
          addr_nxt = fifo_start;
          cnt_nxt  = '0;
          unique case (fifo_cmd.kind)
            KIND_IGNORE: begin
              out_valid_nxt = 1'b1;
              slot_nxt      = '0;
              old_nxt       = '0;
              fw_nxt        = 1'b0;
              full_nxt      = 1'b0;
              ign_nxt       = 1'b1;
            end
            KIND_FULL: begin
              out_valid_nxt = 1'b1;
              slot_nxt      = '0;
              old_nxt       = '0;
              fw_nxt        = 1'b0;
              full_nxt      = 1'b1;
              ign_nxt       = 1'b0;
            end
            default: begin
              state_nxt = B_PROBE;
            end
          endcase
        end
      end
      B_PROBE: begin
        if (claim) begin
          we            = 1'b1;
          out_valid_nxt = 1'b1;
          slot_nxt      = SLOT_OUT_W'(addr_r);
          old_nxt       = rvec;
          fw_nxt        = cmd_r.mode && ((rvec & bit_mask) == '0);
          full_nxt      = 1'b0;
          ign_nxt       = 1'b0;
          state_nxt     = B_IDLE;
        end else if (cnt_r == LAST) begin
          out_valid_nxt = 1'b1;
          slot_nxt      = '0;
          old_nxt       = '0;
          fw_nxt        = 1'b0;
          full_nxt      = 1'b1;
          ign_nxt       = 1'b0;
          state_nxt     = B_IDLE;
        end else begin
          addr_nxt = addr_inc;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    cnt_r  <= cnt_nxt;
    cmd_r  <= cmd_nxt;
    slot_r <= slot_nxt;
    old_r  <= old_nxt;
    fw_r   <= fw_nxt;
    full_r <= full_nxt;
    ign_r  <= ign_nxt;
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/hashed_access_vector_table.sv
// Flow: the front hashes each key; a transaction that is ignored or has key zero is not probed,
//   and a table size that is not a power of two adds a start-slot reduction after the hash.
// The front takes a new transaction only while idle or while pushing the last one; the back
//   does one probe per cycle on the read port of the slot memories.
// Reset: synchronous, active low; the back then clears every slot of both slot memories
//   before it serves a transaction. Monitoring resets to enabled.
// ----------------------------------------------------------------------------
// hashed_access_vector_table
// Hash table of object keys with per-slot access vectors, linear probing.
// ----------------------------------------------------------------------------
module hashed_access_vector_table import hav_pkg::*; #(
  parameter int TABLE_ENTRIES = 512,
  parameter int TASK_SLOTS    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [KEY_W-1:0]      in_key,
  input  logic [ORDER_W-1:0]    in_task_order,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SLOT_OUT_W-1:0] out_slot_index,
  output logic [VEC_W-1:0]      out_prior_vector,
  output logic                  out_first_write,
  output logic                  out_table_full,
  output logic                  out_ignored
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int FW    = $bits(hav_cmd_t) + IDX_W;

  hav_cmd_t         front_cmd, back_cmd;
  logic [IDX_W-1:0] front_start;
  logic             front_push;
  logic             fifo_full;
  logic             fifo_valid;
  logic             fifo_pop;
  logic [FW-1:0]    fifo_rdata;

  hav_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TASK_SLOTS    (TASK_SLOTS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_key        (in_key),
    .in_task_order (in_task_order),
    .push          (front_push),
    .fifo_full     (fifo_full),
    .cmd           (front_cmd),
    .start         (front_start)
  );

  hav_fifo #(.WIDTH(FW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .wdata ({front_cmd, front_start}),
    .full  (fifo_full),
    .pop   (fifo_pop),
    .valid (fifo_valid),
    .rdata (fifo_rdata)
  );

  assign back_cmd = fifo_rdata[FW-1:IDX_W];

  hav_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fifo_valid       (fifo_valid),
    .fifo_cmd         (back_cmd),
    .fifo_start       (fifo_rdata[IDX_W-1:0]),
    .fifo_pop         (fifo_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot_index   (out_slot_index),
    .out_prior_vector (out_prior_vector),
    .out_first_write  (out_first_write),
    .out_table_full   (out_table_full),
    .out_ignored      (out_ignored)
  );

endmodule

>>> verif/hashed_access_vector_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_access_vector_table_test
// Self-checking bench for the hashed access vector table. A queue-fed driver
// sends accesses, predicts each accepted one against a shadow copy of the
// slot keys and vectors, and a monitor checks every result in order. The run
// covers directed corner keys, hash collisions and wrap-around, monitoring
// on and off, random traffic under four idle profiles, and a full table.
// ----------------------------------------------------------------------------
module hashed_access_vector_table_test;
  import hav_pkg::*;

  localparam int ENTRIES  = 512;
  localparam int ORDERS   = 32;
  localparam int PHASE_N  = 400;

  typedef struct packed {
    logic               mode;
    logic [KEY_W-1:0]   key;
    logic [ORDER_W-1:0] order;
  } access_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic [VEC_W-1:0]      old_vec;
    logic                  first_write;
    logic                  table_full;
    logic                  ignored;
  } lookup_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_wdata = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_mode = 1'b0;
  logic [KEY_W-1:0]      in_key = '0;
  logic [ORDER_W-1:0]    in_task_order = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SLOT_OUT_W-1:0] out_slot_index;
  logic [VEC_W-1:0]      out_prior_vector;
  logic                  out_first_write;
  logic                  out_table_full;
  logic                  out_ignored;

  hashed_access_vector_table #(
    .TABLE_ENTRIES(ENTRIES),
    .TASK_SLOTS(ORDERS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_key(in_key),
    .in_task_order(in_task_order),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_slot_index(out_slot_index),
    .out_prior_vector(out_prior_vector),
    .out_first_write(out_first_write),
    .out_table_full(out_table_full),
    .out_ignored(out_ignored)
  );

  access_t          access_queue[$];
  lookup_t          expected_lookups[$];
  logic [KEY_W-1:0] object_pool[$];
  bit               stored_keys[logic [KEY_W-1:0]];
  logic [KEY_W-1:0] shadow_key[ENTRIES];
  logic [VEC_W-1:0] shadow_vec[ENTRIES];
  bit               monitor_on = 1'b1;
  access_t          cur_access;
  lookup_t          want;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               errors = 0;
  int               n_accepted = 0;
  int               n_ignored = 0;
  int               n_full = 0;
  int               n_first_write = 0;
  int               send_idle_steps[4] = '{0, 78, 0, 25};
  int               recv_stall_steps[4] = '{0, 0, 78, 25};

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i] = '0;
      shadow_vec[i] = '0;
    end
  end

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] key_hash(logic [63:0] k);
    k = ~k + (k << 21);
    k = k ^ (k >> 24);
    k = k * 64'd265;
    k = k ^ (k >> 14);
    k = k * 64'd21;
    k = k ^ (k >> 28);
    k = k + (k << 31);
    return k;
  endfunction

  function automatic lookup_t predict_lookup(access_t a);
    lookup_t          r;
    logic [63:0]      mask;
    int               start;
    int               idx;
    bit               hit;
    r = '0;
    idx = 0;
    hit = 1'b0;
    if (!monitor_on) begin
      r.ignored = 1'b1;
      return r;
    end
    if (a.key == '0) begin
      r.table_full = 1'b1;
      return r;
    end
    start = int'(key_hash(a.key) % ENTRIES);
    for (int p = 0; p < ENTRIES && !hit; p++) begin
      idx = (start + p) % ENTRIES;
      if (shadow_key[idx] == a.key) begin
        hit = 1'b1;
      end else if (shadow_key[idx] == '0) begin
        shadow_key[idx] = a.key;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      r.table_full = 1'b1;
      return r;
    end
    mask = 64'd1 << {5'(a.order % ORDERS), a.mode};
    r.slot = idx[SLOT_OUT_W-1:0];
    r.old_vec = shadow_vec[idx];
    r.first_write = a.mode && ((shadow_vec[idx] & mask) == '0);
    shadow_vec[idx] = shadow_vec[idx] | mask;
    return r;
  endfunction

  function automatic logic [63:0] fresh_key();
    logic [63:0] k;
    do k = {$urandom, $urandom}; while (k == '0 || stored_keys.exists(k));
    return k;
  endfunction

  function automatic logic [63:0] key_at_slot(int start);
    logic [63:0] k;
    do k = fresh_key(); while (int'(key_hash(k) % ENTRIES) != start);
    return k;
  endfunction

  task automatic queue_access(logic [63:0] key, logic mode, logic [ORDER_W-1:0] order);
    access_t a;
    a.key = key;
    a.mode = mode;
    a.order = order;
    if (monitor_on && key != '0) stored_keys[key] = 1'b1;
    access_queue.push_back(a);
  endtask

  task automatic queue_random_access();
    logic [63:0] k;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 86) k = object_pool[$urandom_range(object_pool.size() - 1)];
    else if (pick < 97) k = fresh_key();
    else k = '0;
    queue_access(k, 1'($urandom_range(1)), 5'($urandom_range(ORDERS - 1)));
  endtask

  task automatic wait_drained();
    while (access_queue.size() != 0 || in_valid || expected_lookups.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_monitor(bit on);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    cfg_we <= 1'b0;
    monitor_on = on;
  endtask

  // driver: predict on acceptance, then present the next transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        want = predict_lookup(cur_access);
        expected_lookups.push_back(want);
        n_accepted++;
        if (want.ignored) n_ignored++;
        if (want.table_full) n_full++;
        if (want.first_write) n_first_write++;
      end
      if (!in_valid || in_ready) begin
        if (access_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_access = access_queue.pop_front();
          in_valid <= 1'b1;
          in_mode <= cur_access.mode;
          in_key <= cur_access.key;
          in_task_order <= cur_access.order;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lookups.size() == 0) begin
          $error("unexpected result: slot_index %0d", out_slot_index);
          errors++;
        end else begin
          lookup_t exp_r;
          exp_r = expected_lookups.pop_front();
          if (out_slot_index !== exp_r.slot) begin
            $error("slot_index: expected %0d, got %0d", exp_r.slot, out_slot_index);
            errors++;
          end
          if (out_prior_vector !== exp_r.old_vec) begin
            $error("prior_vector: expected %h, got %h", exp_r.old_vec, out_prior_vector);
            errors++;
          end
          if (out_first_write !== exp_r.first_write) begin
            $error("first_write: expected %0b, got %0b", exp_r.first_write, out_first_write);
            errors++;
          end
          if (out_table_full !== exp_r.table_full) begin
            $error("table_full: expected %0b, got %0b", exp_r.table_full, out_table_full);
            errors++;
          end
          if (out_ignored !== exp_r.ignored) begin
            $error("ignored: expected %0b, got %0b", exp_r.ignored, out_ignored);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    logic [63:0] k1;
    logic [63:0] ones;
    logic [63:0] c1;
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [63:0] k;
    int          base;
    int          need;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_monitor(1'b1);

    k1 = 64'd1;
    ones = '1;
    c1 = key_at_slot(int'(key_hash(k1) % ENTRIES));
    w0 = key_at_slot(ENTRIES - 1);
    w1 = key_at_slot(ENTRIES - 1);
    w2 = key_at_slot(ENTRIES - 1);

    queue_access(k1, 1'b1, 5'd0);
    queue_access(k1, 1'b1, 5'd0);
    queue_access(k1, 1'b0, 5'd31);
    queue_access(ones, 1'b1, 5'd31);
    queue_access(ones, 1'b0, 5'd0);
    queue_access(64'd0, 1'b1, 5'd0);
    queue_access(64'd0, 1'b0, 5'd31);
    queue_access(c1, 1'b1, 5'd5);
    queue_access(c1, 1'b0, 5'd5);
    queue_access(w0, 1'b1, 5'd31);
    queue_access(w1, 1'b1, 5'd1);
    queue_access(w2, 1'b0, 5'd2);
    queue_access(w1, 1'b1, 5'd1);
    queue_access(64'h8000_0000_0000_0000, 1'b0, 5'd16);
    queue_access(64'h5555_5555_5555_5555, 1'b1, 5'd10);
    queue_access(64'haaaa_aaaa_aaaa_aaaa, 1'b1, 5'd21);
    queue_access(k1, 1'b1, 5'd31);
    wait_drained();

    set_monitor(1'b0);
    queue_access(k1, 1'b1, 5'd3);
    queue_access(64'd0, 1'b0, 5'd0);
    queue_access(ones, 1'b0, 5'd31);
    wait_drained();
    set_monitor(1'b1);

    object_pool = '{k1, ones, c1, w0, w1, w2, 64'h8000_0000_0000_0000,
                    64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa};
    for (int g = 0; g < 2; g++) begin
      base = $urandom_range(ENTRIES - 1);
      for (int j = 0; j < 4; j++) object_pool.push_back(key_at_slot(base));
    end
    for (int j = 0; j < 40; j++) object_pool.push_back(fresh_key());
    foreach (object_pool[j])
      queue_access(object_pool[j], 1'($urandom_range(1)), 5'($urandom_range(ORDERS - 1)));

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_steps[ph];
      recv_stall_pct = recv_stall_steps[ph];
      for (int n = 0; n < PHASE_N; n++) begin
        if (ph == 1 && n == PHASE_N / 2) wait_drained();
        queue_random_access();
      end
      wait_drained();
      set_monitor(1'b0);
      for (int n = 0; n < 20; n++) begin
        k = ($urandom_range(3) == 0) ? 64'd0 : {$urandom, $urandom};
        queue_access(k, 1'($urandom_range(1)), 5'($urandom_range(ORDERS - 1)));
      end
      wait_drained();
      set_monitor(1'b1);
    end

    // fill every free slot, then overflow
    send_idle_pct = 0;
    recv_stall_pct = 0;
    need = ENTRIES - stored_keys.num();
    for (int n = 0; n < need; n++)
      queue_access(fresh_key(), 1'($urandom_range(1)), 5'($urandom_range(ORDERS - 1)));
    for (int n = 0; n < 6; n++) begin
      queue_access(fresh_key(), 1'($urandom_range(1)), 5'($urandom_range(ORDERS - 1)));
      queue_access(object_pool[$urandom_range(object_pool.size() - 1)],
                   1'($urandom_range(1)), 5'($urandom_range(ORDERS - 1)));
    end
    queue_access(64'd0, 1'b1, 5'd31);
    wait_drained();

    repeat (30) @(posedge clk);
    if (expected_lookups.size() != 0) begin
      $error("%0d results never arrived", expected_lookups.size());
      errors++;
    end
    $display("Checked %0d accesses: %0d ignored, %0d table full, %0d first writes.",
             n_accepted, n_ignored, n_full, n_first_write);
    $display("Traffic ran under four idle profiles and ended with all %0d slots taken.",
             ENTRIES);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #48_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
